/* design/m3i_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, types and constants of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int EW     = 32;
  localparam int NEL    = 9;
  localparam int PW     = 64;
  localparam int CW     = 65;
  localparam int CMW    = CW - 1;
  localparam int DW     = 99;
  localparam int DMW    = DW - 1;
  localparam int QW     = 32;
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  localparam logic [QW-1:0] POS_SAT = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] NEG_SAT = 32'h8000_0000;

  typedef logic signed [EW-1:0] elem_t;

  typedef struct packed {
    logic [DMW-1:0]          dmag;
    logic                    sing;
    logic [NEL-1:0]          neg;
    logic [NEL-1:0][CMW-1:0] cmag;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

/* design/m3i_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_front
// Accepts matrices, forms cofactors and the determinant, and splits both into
// sign and magnitude for the divider lanes.
// ----------------------------------------------------------------------------
module m3i_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [m3i_pkg::NEL*m3i_pkg::EW-1:0] in_tdata,
  input  wire m3i_pkg::qstat_t               q_stat,
  output logic                               push,
  output m3i_pkg::qent_t                     push_ent
);

  localparam int DW  = m3i_pkg::DW;
  localparam int CW  = m3i_pkg::CW;
  localparam int CMW = m3i_pkg::CMW;
  localparam int DMW = m3i_pkg::DMW;
  localparam int EW  = m3i_pkg::EW;
  localparam logic [DW-1:0] ONE_SCALE = DW'(1) << (3 * FRAC_BITS);
  localparam logic [DW-1:0] DET_EPS   = (ONE_SCALE + DW'(50)) / DW'(100);

  logic                      fe;
  logic [6:0]                v_r;
  m3i_pkg::elem_t            a_r   [9];
  logic signed [63:0]        pa_r  [9];
  logic signed [63:0]        pb_r  [9];
  logic signed [63:0]        pa_nxt[9];
  logic signed [63:0]        pb_nxt[9];
  m3i_pkg::elem_t            r1_r  [3];
  m3i_pkg::elem_t            r2_r  [3];
  logic signed [CW-1:0]      cof2_r[9];
  logic signed [CW-1:0]      cof3_r[9];
  logic signed [CW-1:0]      cof4_r[9];
  logic signed [CW-1:0]      cof5_r[9];
  logic signed [CW-1:0]      ph_r  [3];
  logic signed [CW-1:0]      pl_r  [3];
  logic signed [DW-1:0]      t_r   [3];
  logic signed [DW-1:0]      det_r;
  logic                      sing_c;
  logic signed [DW-1:0]      dsel_c;
  m3i_pkg::qent_t            ent_nxt;
  m3i_pkg::qent_t            ent_r;

  assign fe        = !(v_r[6] && q_stat.full);
  assign in_tready = fe;
  assign push      = v_r[6] && !q_stat.full;
  assign push_ent  = ent_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pa_nxt[i*3+j] = a_r[((j+1)%3)*3 + (i+1)%3] * a_r[((j+2)%3)*3 + (i+2)%3];
        pb_nxt[i*3+j] = a_r[((j+1)%3)*3 + (i+2)%3] * a_r[((j+2)%3)*3 + (i+1)%3];
      end
    end
  end

  always_comb begin
    sing_c = (det_r == '0);
    dsel_c = sing_c ? $signed(DET_EPS) : det_r;
    ent_nxt.sing = sing_c;
    ent_nxt.dmag = dsel_c[DW-1] ? DMW'(-dsel_c) : DMW'(dsel_c);
    for (int k = 0; k < 9; k++) begin
      ent_nxt.neg[k]  = cof5_r[k][CW-1] ^ dsel_c[DW-1];
      ent_nxt.cmag[k] = cof5_r[k][CW-1] ? CMW'(-cof5_r[k]) : CMW'(cof5_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fe) begin
      v_r <= {v_r[5:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      for (int k = 0; k < 9; k++) begin
        a_r[k]    <= in_tdata[k*EW +: EW];
        pa_r[k]   <= pa_nxt[k];
        pb_r[k]   <= pb_nxt[k];
        cof2_r[k] <= CW'(pa_r[k]) - CW'(pb_r[k]);
        cof3_r[k] <= cof2_r[k];
        cof4_r[k] <= cof3_r[k];
        cof5_r[k] <= cof4_r[k];
      end
      for (int i = 0; i < 3; i++) begin
        r1_r[i] <= a_r[i];
        r2_r[i] <= r1_r[i];
        ph_r[i] <= r2_r[i] * $signed(cof2_r[i*3][CW-1:32]);
        pl_r[i] <= r2_r[i] * $signed({1'b0, cof2_r[i*3][31:0]});
        t_r[i]  <= (DW'(ph_r[i]) <<< 32) + DW'(pl_r[i]);
      end
      det_r <= t_r[0] + t_r[1] + t_r[2];
      ent_r <= ent_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/m3i_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_queue
// Two-entry queue between the cofactor front and the divider back.
// ----------------------------------------------------------------------------
module m3i_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire m3i_pkg::qent_t  push_ent,
  input  wire logic            pop,
  output m3i_pkg::qent_t       head,
  output m3i_pkg::qstat_t      stat
);

  m3i_pkg::qent_t                 mem_r [m3i_pkg::QDEPTH];
  logic [m3i_pkg::QAW-1:0]        wp_r;
  logic [m3i_pkg::QAW-1:0]        rp_r;
  logic [m3i_pkg::QCW-1:0]        cnt_r;
  logic [m3i_pkg::QCW-1:0]        cnt_nxt;

  assign head       = mem_r[rp_r];
  assign stat.full  = (cnt_r == m3i_pkg::QCW'(m3i_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_ent;
    end
  end

endmodule
`default_nettype wire

/* design/m3i_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_lane
// One pipelined restoring divider: scaled cofactor magnitude over determinant
// magnitude, one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module m3i_lane #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      en,
  input  wire logic [m3i_pkg::CMW-1:0]                   cmag,
  input  wire logic                                      neg,
  input  wire logic [m3i_pkg::DMW-1:0]                   dmag_in,
  input  wire logic [m3i_pkg::QW-1:0][m3i_pkg::DMW-1:0]  dmag_pipe,
  output logic [m3i_pkg::QW-1:0]                         res
);

  localparam int QW  = m3i_pkg::QW;
  localparam int DMW = m3i_pkg::DMW;
  localparam int RW  = DMW + 1;
  localparam int NW  = m3i_pkg::CMW + 2 * FRAC_BITS;

  logic [NW-1:0]  n_c;
  logic [DMW-1:0] r_r   [QW+1];
  logic [DMW-1:0] r_nxt [QW+1];
  logic [QW-1:0]  lo_r  [QW+1];
  logic [QW-1:0]  lo_nxt[QW+1];
  logic [QW-1:0]  q_r   [QW+1];
  logic [QW-1:0]  q_nxt [QW+1];
  logic [QW:0]    big_r;
  logic [QW:0]    neg_r;
  logic [RW-1:0]  t_c   [QW+1];
  logic [QW:0]    ge_c;
  logic [QW-1:0]  res_nxt;
  logic [QW-1:0]  res_r;

  assign res = res_r;

  always_comb begin
    n_c       = {cmag, {(2 * FRAC_BITS){1'b0}}};
    r_nxt[0]  = DMW'(n_c[NW-1:QW]);
    lo_nxt[0] = n_c[QW-1:0];
    q_nxt[0]  = '0;
    t_c[0]    = '0;
    ge_c[0]   = 1'b0;
    for (int k = 1; k <= QW; k++) begin
      t_c[k]    = {r_r[k-1], lo_r[k-1][QW-1]};
      ge_c[k]   = (t_c[k] >= {1'b0, dmag_pipe[k-1]});
      r_nxt[k]  = ge_c[k] ? DMW'(t_c[k] - {1'b0, dmag_pipe[k-1]}) : DMW'(t_c[k]);
      lo_nxt[k] = {lo_r[k-1][QW-2:0], 1'b0};
      q_nxt[k]  = {q_r[k-1][QW-2:0], ge_c[k]};
    end
    if (!neg_r[QW]) begin
      res_nxt = (big_r[QW] || q_r[QW][QW-1]) ? m3i_pkg::POS_SAT : q_r[QW];
    end else begin
      res_nxt = (big_r[QW] || (q_r[QW] > m3i_pkg::NEG_SAT)) ? m3i_pkg::NEG_SAT
                                                            : (QW'(0) - q_r[QW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big_r[0] <= (r_nxt[0] >= dmag_in);
      neg_r[0] <= neg;
      for (int k = 0; k <= QW; k++) begin
        r_r[k]  <= r_nxt[k];
        lo_r[k] <= lo_nxt[k];
        q_r[k]  <= q_nxt[k];
      end
      big_r[QW:1] <= big_r[QW-1:0];
      neg_r[QW:1] <= neg_r[QW-1:0];
      res_r       <= res_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/m3i_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// m3i_back
// Nine divider lanes sharing one determinant pipeline and one stall enable,
// ending in the output register.
// ----------------------------------------------------------------------------
module m3i_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire m3i_pkg::qstat_t                      q_stat,
  input  wire m3i_pkg::qent_t                       head,
  output logic                                      pop,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [m3i_pkg::NEL*m3i_pkg::QW-1:0]       out_tdata,
  output logic                                      out_tuser
);

  localparam int QW = m3i_pkg::QW;

  logic                                     be;
  logic [QW+1:0]                            bv_r;
  logic [QW+1:0]                            s_r;
  logic [QW-1:0][m3i_pkg::DMW-1:0]          d_r;

  assign be         = !bv_r[QW+1] || out_tready;
  assign pop        = be && !q_stat.empty;
  assign out_tvalid = bv_r[QW+1];
  assign out_tuser  = s_r[QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (be) begin
      bv_r <= {bv_r[QW:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      s_r <= {s_r[QW:0], head.sing};
      d_r <= {d_r[QW-2:0], head.dmag};
    end
  end

  for (genvar g = 0; g < m3i_pkg::NEL; g++) begin : g_lane
    m3i_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk       (clk),
      .en        (be),
      .cmag      (head.cmag[g]),
      .neg       (head.neg[g]),
      .dmag_in   (head.dmag),
      .dmag_pipe (d_r),
      .res       (out_tdata[g*QW +: QW])
    );
  end

endmodule
`default_nettype wire

/* design/matrix_3x3_inverse.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_3x3_inverse
// Inverse of a 3x3 Q-format matrix by the adjugate, with saturation and a
// flag when a zero determinant was replaced by 0.01.
// ----------------------------------------------------------------------------
// Channel  Ports           Contents
// in       in_t*  288 b    a_00 .. a_22, 32 bits each
// out      out_t* 288 b    inv_00 .. inv_22, 32 bits each; tuser: singular
//
// One item is accepted per cycle when the output is taken every cycle.
// The path runs through seven front stages, the queue, and 34 divider stages,
// set by the one-bit-per-stage restoring dividers in the nine lanes.
// A stalled output holds the back end; the queue then fills and stalls the front.
// Reset clears only the valid bits and the queue pointers and count.
// ----------------------------------------------------------------------------
module matrix_3x3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [287:0]  in_tdata,   // a_00, a_01, a_02, a_10 .. a_22
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [287:0]       out_tdata,  // inv_00, inv_01, inv_02, inv_10 .. inv_22
  output logic               out_tuser   // singular
);

  logic             push;
  logic             pop;
  m3i_pkg::qent_t   push_ent;
  m3i_pkg::qent_t   head;
  m3i_pkg::qstat_t  q_stat;

  m3i_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_ent  (push_ent)
  );

  m3i_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  m3i_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue read while empty");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !pop) |=> q_stat.full) else $error("queue lost an item");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_stat.full) else $error("front stalled with queue space");

endmodule
`default_nettype wire

/* sim/matrix_3x3_inverse_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_3x3_inverse_tb
// Streams a directed table of matrices and then random matrices through the
// inverse block with random gaps and output stalls. Each item is checked element
// by element against a listed inverse or an exact adjugate-and-divide predictor.
// ----------------------------------------------------------------------------
module matrix_3x3_inverse_tb;

  localparam int FB          = 16;
  localparam int N_RANDOM    = 530;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 60;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [31:0] inv [9];
    logic        sing;
  } inverse_t;

  typedef struct {
    logic [31:0] a [9];
    bit          literal;
    logic [31:0] inv [9];
    logic        sing;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;
  logic         out_tuser;

  inverse_t inverse_q [$];
  int       mismatches;
  int       cycles;
  bit       stim_done;

  matrix_3x3_inverse #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic inverse_t invert(input logic [31:0] m [9]);
    wide_t    e [3][3];
    wide_t    det, cof, dmag, cmag;
    logic [127:0] qm;
    bit       dneg, neg;
    int       p, q, r1, r2, c1, c2;
    inverse_t res;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] = wide_t'(signed'(m[i*3+j]));
    det = 0;
    for (int i = 0; i < 3; i++) begin
      p = (i + 1) % 3;
      q = (i + 2) % 3;
      det = det + e[0][i] * e[1][p] * e[2][q] - e[2][i] * e[1][p] * e[0][q];
    end
    res.sing = (det == 0);
    if (res.sing) det = ((wide_t'(1) <<< (3 * FB)) + 50) / 100;
    dneg = det < 0;
    dmag = dneg ? -det : det;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r1 = (j + 1) % 3; r2 = (j + 2) % 3;
        c1 = (i + 1) % 3; c2 = (i + 2) % 3;
        cof = e[r1][c1] * e[r2][c2] - e[r1][c2] * e[r2][c1];
        neg = (cof < 0) != dneg;
        cmag = (cof < 0) ? -cof : cof;
        qm = (unsigned'(cmag) << (2 * FB)) / unsigned'(dmag);
        if (!neg) res.inv[i*3+j] = (qm > 128'h7FFF_FFFF) ? m3i_pkg::POS_SAT : qm[31:0];
        else      res.inv[i*3+j] = (qm > 128'h8000_0000) ? m3i_pkg::NEG_SAT : 32'd0 - qm[31:0];
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_elem(input int kind);
    logic [31:0] v;
    case (kind)
      0: v = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      1: v = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          4: v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic row_t plain(input logic [31:0] a0, a1, a2, a3, a4, a5, a6, a7, a8);
    row_t r;
    r.a = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    r.literal = 1'b0;
    r.inv = '{default: 32'd0};
    r.sing = 1'b0;
    return r;
  endfunction

  task automatic send_matrix(input logic [31:0] m [9], input inverse_t exp_inv);
    int  gap;
    bit  taken;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    for (int k = 0; k < 9; k++) in_tdata[32*k +: 32] <= m[k];
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    inverse_q.push_back(exp_inv);
  endtask

  initial begin
    row_t        table_rows [$];
    row_t        r;
    logic [31:0] m [9];
    inverse_t    x;
    int          kind;
    int          shape;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    mismatches = 0;
    stim_done  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    r = plain(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000);
    r.literal = 1'b1;
    r.inv = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000};
    r.sing = 1'b0;
    table_rows.push_back(r);
    r = plain(0, 0, 0, 0, 0, 0, 0, 0, 0);
    r.literal = 1'b1;
    r.sing = 1'b1;
    table_rows.push_back(r);
    table_rows.push_back(plain(32'h0002_0000, 0, 0, 0, 32'h0004_0000, 0, 0, 0,
                               32'hFFFF_0000));
    table_rows.push_back(plain(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0,
                               32'h7FFF_FFFF));
    table_rows.push_back(plain(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0,
                               32'h8000_0000));
    table_rows.push_back(plain(1, 0, 0, 0, 1, 0, 0, 0, 1));
    table_rows.push_back(plain(32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 1));
    table_rows.push_back(plain(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    table_rows.push_back(plain(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    table_rows.push_back(plain(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                               32'h0002_0000, 32'h0004_0000, 32'h0006_0000,
                               32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
    table_rows.push_back(plain(32'h0002_0000, 32'hFFFF_0000, 0, 32'hFFFF_0000,
                               32'h0002_0000, 32'hFFFF_0000, 0, 32'hFFFF_0000,
                               32'h0002_0000));
    table_rows.push_back(plain(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0, 0,
                               32'h0001_0000));
    table_rows.push_back(plain(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    table_rows.push_back(plain(32'h0000_0100, 0, 0, 0, 32'h0000_0100, 0, 0, 0,
                               32'h0000_0100));
    table_rows.push_back(plain(32'h0100_0000, 32'h0000_0001, 0, 0, 32'h0100_0000,
                               0, 0, 0, 32'h0100_0000));

    foreach (table_rows[n]) begin
      if (table_rows[n].literal) begin
        x.inv  = table_rows[n].inv;
        x.sing = table_rows[n].sing;
      end else begin
        x = invert(table_rows[n].a);
      end
      send_matrix(table_rows[n].a, x);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      shape = $urandom_range(0, 99);
      kind = (shape < 60) ? 0 : (shape < 80) ? 1 : 2;
      for (int k = 0; k < 9; k++) m[k] = rand_elem(kind);
      if (shape >= 85) begin
        case ($urandom_range(0, 2))
          0: for (int k = 0; k < 3; k++) m[6+k] = m[k];
          1: for (int k = 0; k < 3; k++) m[3*k+1] = 32'd0;
          default: for (int k = 0; k < 3; k++) m[3+k] = 32'd0 - m[k];
        endcase
      end
      send_matrix(m, invert(m));
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    inverse_t    exp_inv;
    logic [31:0] got;
    int          stall;
    bit          taken;
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_tvalid;
        if (taken) begin
          if (inverse_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with nothing expected: %h", out_tdata);
          end else begin
            exp_inv = inverse_q.pop_front();
            for (int k = 0; k < 9; k++) begin
              got = out_tdata[32*k +: 32];
              if (got !== exp_inv.inv[k]) begin
                mismatches++;
                if (mismatches <= 10)
                  $display("inv element %0d: expected %h, got %h", k, exp_inv.inv[k], got);
              end
            end
            if (out_tuser !== exp_inv.sing) begin
              mismatches++;
              if (mismatches <= 10)
                $display("singular: expected %b, got %b", exp_inv.sing, out_tuser);
            end
          end
        end
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && inverse_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
